FILE: hw/rtl/vtd_pkg.sv
// -----------------------------------------------------------------------------
// vtd_pkg
// Shared types and constants for the vertex tuple deduplication table.
// -----------------------------------------------------------------------------
`default_nettype none

package vtd_pkg;

	// element width and number of elements carried by one transfer
	localparam int ELEM_BITS   = 24;
	localparam int IN_ELEMS    = 4;
	localparam int RIDX_BITS   = 8;
	localparam int OIDX_BITS   = 8;
	localparam int OCNT_BITS   = 9;
	localparam int IN_TDATA_W  = 104;
	localparam int OUT_TDATA_W = 120;
	localparam int OUT_TUSER_W = 3;

	// register map, indexed by paddr[2]
	localparam logic REG_STRIDE = 1'b0;

	typedef enum logic [1:0] {
		CMD_UNIQUE = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_READ   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	// per-lane RAM strobes, shared by every lane
	typedef struct packed {
		logic we;
		logic re;
	} ram_ctrl_t;

	typedef struct packed {
		logic [IN_ELEMS-1:0][ELEM_BITS-1:0] elems;
		logic [OCNT_BITS-1:0]               entry_count;
		logic                               bad_index;
		logic                               overflow;
		logic                               found;
		logic [OIDX_BITS-1:0]               entry_index;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vtd_ram.sv
// -----------------------------------------------------------------------------
// vtd_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module vtd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vtd_lane.sv
// -----------------------------------------------------------------------------
// vtd_lane
// One element lane: a column of the tuple store plus its equality compare.
// -----------------------------------------------------------------------------
`default_nettype none

module vtd_lane #(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  wire logic                         clk,
	input  wire vtd_pkg::ram_ctrl_t           ctrl,
	input  wire logic [IDX_W-1:0]             waddr,
	input  wire logic [IDX_W-1:0]             raddr,
	input  wire logic [vtd_pkg::ELEM_BITS-1:0] key,
	output logic      [vtd_pkg::ELEM_BITS-1:0] rdata,
	output logic                              eq
);

	vtd_ram #(
		.WIDTH (vtd_pkg::ELEM_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ctrl.we),
		.waddr (waddr),
		.wdata (key),
		.re    (ctrl.re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// key is held for the whole scan, so the stored row meets it directly
	assign eq = (rdata == key);

endmodule

`default_nettype wire

FILE: hw/rtl/vtd_merge.sv
// -----------------------------------------------------------------------------
// vtd_merge
// Combines lane compares into one hit and masks read elements by stride.
// -----------------------------------------------------------------------------
`default_nettype none

module vtd_merge #(
	parameter int LANES = 4
) (
	input  wire logic [LANES-1:0]                               lane_on,
	input  wire logic [LANES-1:0]                               eq,
	input  wire logic [LANES-1:0][vtd_pkg::ELEM_BITS-1:0]       rdata,
	output logic                                                hit,
	output logic [vtd_pkg::IN_ELEMS-1:0][vtd_pkg::ELEM_BITS-1:0] elems
);

	// lanes beyond the stride do not take part in the compare
	assign hit = &(eq | ~lane_on);

	for (genvar k = 0; k < vtd_pkg::IN_ELEMS; k++) begin : g_elem
		if (k < LANES) begin : g_on
			assign elems[k] = lane_on[k] ? rdata[k] : '0;
		end else begin : g_off
			assign elems[k] = '0;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/vertex_tuple_dedup_table_core.sv
// -----------------------------------------------------------------------------
// vertex_tuple_dedup_table_core - vertex tuple deduplication table
// Steps: plain add passes APPEND then FINISH, a read passes RDWAIT then FINISH,
// an unknown command or a read past the count goes straight to FINISH; unique
// add on an empty table passes APPEND then FINISH, else it first scans the lane
// RAMs at one stored row per cycle and goes on to FINISH on a hit or to APPEND
// after the last row. One item is in work at a time; the next transfer is taken
// the cycle after the result reaches the output register.
// Reset empties the table and sets stride to 1; the RAM contents are not
// cleared, the entry count alone marks what is valid.
// -----------------------------------------------------------------------------
`default_nettype none

module vertex_tuple_dedup_table_core #(
	parameter int ENTRIES    = 256,
	parameter int MAX_STRIDE = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,

	// APB-style register port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [2:0]                          paddr,
	input  wire logic [31:0]                         pwdata,
	output logic      [31:0]                         prdata,
	output logic                                     pready,

	// input stream
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// tdata, low to high: elem_0, elem_1, elem_2, elem_3, read_index
	input  wire logic [vtd_pkg::IN_TDATA_W-1:0]      s_tdata,
	// tuser: command
	input  wire logic [1:0]                          s_tuser,

	// result stream
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// tdata, low to high: entry_index, entry_count, out_elem_0..3, zero pad
	output logic      [vtd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// tuser, low to high: found, overflow, bad_index
	output logic      [vtd_pkg::OUT_TUSER_W-1:0]     m_tuser
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (CNT_W > vtd_pkg::RIDX_BITS) ? CNT_W : vtd_pkg::RIDX_BITS;
	localparam logic [CNT_W-1:0] ENTRIES_C = CNT_W'(ENTRIES);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_APPEND = 5'b00100,
		ST_RDWAIT = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [2:0]            stride_q;
	logic [CNT_W-1:0]      issue_q;
	logic                  dv_s1;
	logic [CNT_W-1:0]      row_s1;
	logic                  out_valid_q;
	vtd_pkg::res_t         res_q;
	vtd_pkg::res_t         out_q;

	logic [MAX_STRIDE-1:0]                          lane_on_q;
	logic [MAX_STRIDE-1:0][vtd_pkg::ELEM_BITS-1:0]  key_q;

	// ---------------------------------------------------------------------
	// Register port: stride only, unguarded; user must write it while block idles
	// ---------------------------------------------------------------------
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == vtd_pkg::REG_STRIDE);
	assign prdata = (paddr[2] == vtd_pkg::REG_STRIDE) ? {29'd0, stride_q} : '0;

	// Effective stride: zero acts as one, anything above MAX_STRIDE clamps
	logic [3:0] s_eff;

	always_comb begin
		if (stride_q == 3'd0) begin
			s_eff = 4'd1;
		end else if ({1'b0, stride_q} > 4'(MAX_STRIDE)) begin
			s_eff = 4'(MAX_STRIDE);
		end else begin
			s_eff = {1'b0, stride_q};
		end
	end

	// ---------------------------------------------------------------------
	// Input decode
	// ---------------------------------------------------------------------
	logic                                           in_xfer;
	vtd_pkg::cmd_t                                  in_cmd;
	logic [vtd_pkg::RIDX_BITS-1:0]                  in_ridx;
	logic                                           ri_bad;
	logic [MAX_STRIDE-1:0]                          lane_on_d;
	logic [MAX_STRIDE-1:0][vtd_pkg::ELEM_BITS-1:0]  key_d;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign in_cmd   = vtd_pkg::cmd_t'(s_tuser);
	assign in_ridx  = s_tdata[vtd_pkg::IN_ELEMS*vtd_pkg::ELEM_BITS +: vtd_pkg::RIDX_BITS];
	// count never exceeds ENTRIES, so this also covers indices beyond the store
	assign ri_bad   = CMP_W'(in_ridx) >= CMP_W'(count_q);

	// Lanes above the stride store zeros, lanes beyond the input get zeros
	for (genvar k = 0; k < MAX_STRIDE; k++) begin : g_key
		assign lane_on_d[k] = (4'(k) < s_eff);
		if (k < vtd_pkg::IN_ELEMS) begin : g_in
			assign key_d[k] = lane_on_d[k] ?
				s_tdata[k*vtd_pkg::ELEM_BITS +: vtd_pkg::ELEM_BITS] : '0;
		end else begin : g_zero
			assign key_d[k] = '0;
		end
	end

	// ---------------------------------------------------------------------
	// Lane array: one RAM column and comparator per tuple element
	// ---------------------------------------------------------------------
	vtd_pkg::ram_ctrl_t                             ram_ctrl;
	logic [IDX_W-1:0]                               raddr;
	logic [IDX_W-1:0]                               waddr;
	logic                                           room;
	logic                                           last_row;
	logic                                           out_free;
	logic [MAX_STRIDE-1:0]                          lane_eq;
	logic [MAX_STRIDE-1:0][vtd_pkg::ELEM_BITS-1:0]  lane_rdata;
	logic                                           hit;
	logic [vtd_pkg::IN_ELEMS-1:0][vtd_pkg::ELEM_BITS-1:0] rd_elems;

	assign room     = (count_q < ENTRIES_C);
	assign last_row = ((row_s1 + 1'b1) == count_q);
	assign out_free = !out_valid_q || m_tready;

	// Read port: the read index on the input transfer, the scan pointer after
	always_comb begin
		ram_ctrl.re = 1'b0;
		ram_ctrl.we = 1'b0;
		raddr       = issue_q[IDX_W-1:0];
		case (state_q)
			ST_IDLE: begin
				raddr       = IDX_W'(in_ridx);
				ram_ctrl.re = in_xfer && (in_cmd == vtd_pkg::CMD_READ) && !ri_bad;
			end
			ST_SCAN: begin
				ram_ctrl.re = (issue_q < count_q);
			end
			ST_APPEND: begin
				ram_ctrl.we = room;
			end
			default: begin
			end
		endcase
	end

	assign waddr = count_q[IDX_W-1:0];

	for (genvar k = 0; k < MAX_STRIDE; k++) begin : g_lane
		vtd_lane #(
			.DEPTH (ENTRIES),
			.IDX_W (IDX_W)
		) u_lane (
			.clk   (clk),
			.ctrl  (ram_ctrl),
			.waddr (waddr),
			.raddr (raddr),
			.key   (key_q[k]),
			.rdata (lane_rdata[k]),
			.eq    (lane_eq[k])
		);
	end

	vtd_merge #(
		.LANES (MAX_STRIDE)
	) u_merge (
		.lane_on (lane_on_q),
		.eq      (lane_eq),
		.rdata   (lane_rdata),
		.hit     (hit),
		.elems   (rd_elems)
	);

	// ---------------------------------------------------------------------
	// Sequencer: IDLE -> (SCAN) -> (APPEND / RDWAIT) -> FINISH -> IDLE
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			stride_q    <= 3'd1;
			issue_q     <= '0;
			dv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				stride_q <= pwdata[2:0];
			end
			// one row issued per cycle in the scan, its data compared in the cycle after
			dv_s1       <= (state_q == ST_SCAN) && ram_ctrl.re && !(dv_s1 && hit);
			out_valid_q <= (out_valid_q && !m_tready) || ((state_q == ST_FINISH) && out_free);

			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (in_cmd)
							vtd_pkg::CMD_UNIQUE: begin
								issue_q <= '0;
								state_q <= (count_q == '0) ? ST_APPEND : ST_SCAN;
							end
							vtd_pkg::CMD_ADD: begin
								state_q <= ST_APPEND;
							end
							vtd_pkg::CMD_READ: begin
								state_q <= ri_bad ? ST_FINISH : ST_RDWAIT;
							end
							default: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (ram_ctrl.re) begin
						issue_q <= issue_q + 1'b1;
					end
					if (dv_s1 && hit) begin
						state_q <= ST_FINISH;
					end else if (dv_s1 && last_row) begin
						state_q <= ST_APPEND;
					end
				end
				ST_APPEND: begin
					if (room) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_FINISH;
				end
				ST_RDWAIT: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan row tag travels beside dv_s1
	always_ff @(posedge clk) begin
		row_s1 <= issue_q;
	end

	// ---------------------------------------------------------------------
	// Payload: key, result being built, output register
	// ---------------------------------------------------------------------
	vtd_pkg::res_t res_init;
	vtd_pkg::res_t res_fin;

	always_comb begin
		res_init = '0;
		if (in_cmd == vtd_pkg::CMD_READ) begin
			res_init.entry_index = in_ridx;
			res_init.bad_index   = ri_bad;
		end
		res_fin             = res_q;
		res_fin.entry_count = vtd_pkg::OCNT_BITS'(count_q);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					key_q     <= key_d;
					lane_on_q <= lane_on_d;
					res_q     <= res_init;
				end
			end
			ST_SCAN: begin
				if (dv_s1 && hit) begin
					{res_q.found, res_q.entry_index} <=
						{1'b1, vtd_pkg::OIDX_BITS'(row_s1)};
				end
			end
			ST_APPEND: begin
				if (room) begin
					res_q.entry_index <= vtd_pkg::OIDX_BITS'(count_q);
				end else begin
					res_q.overflow <= 1'b1;
				end
			end
			ST_RDWAIT: begin
				res_q.elems <= rd_elems;
			end
			ST_FINISH: begin
				if (out_free) begin
					out_q <= res_fin;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.elems, out_q.entry_count, out_q.entry_index};
	assign m_tuser  = {out_q.bad_index, out_q.overflow, out_q.found};

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ($countones({out_q.found, out_q.overflow, out_q.bad_index}) <= 1))
		else $error("more than one result flag set");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(ram_ctrl.we) && (count_q == $past(count_q) + 1'b1)))
		else $error("entry count moved without an append");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && dv_s1 && hit) |-> (row_s1 < count_q))
		else $error("scan matched a row beyond the count");

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dv_s1)
		else $error("scan data in flight while idle");

endmodule

`default_nettype wire
